// ===== hdl/otq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otq_pkg
// Shared types and constants of the ordered timer queue.
// ----------------------------------------------------------------------------
package otq_pkg;

    localparam int TIMER_SLOTS = 16;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] time_us;
        logic [31:0] repeat_interval;
        logic [3:0]  cancel_slot;
        logic [15:0] cancel_tag;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] tag;
        logic        accepted;
        logic        fired;
        logic        earliest_changed;
        logic        next_valid;
        logic [47:0] next_expiry;
        logic        last;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word
        logic scan_clr;  // start a scan pass
        logic scan_step; // examine one slot
        logic do_add;
        logic do_cancel;
        logic do_fire;   // fire picked slot
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic        scan_done;
        logic        found;
        logic        next_valid;
        logic [47:0] next_expiry;
    } t_status;

endpackage
`default_nettype wire

// ===== hdl/otq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otq_datapath
// Timer table, scan unit for earliest and due timers, result word builder.
// ----------------------------------------------------------------------------
module otq_datapath #(
    parameter int SLOTS = otq_pkg::TIMER_SLOTS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire otq_pkg::t_in_word i_in,
    input  wire otq_pkg::t_cmd     i_cmd,
    output otq_pkg::t_status       o_status,
    output otq_pkg::t_out_word     o_res
);
    localparam int SW = $clog2(SLOTS);

    logic [47:0] r_exp [SLOTS];
    logic [31:0] r_ivl [SLOTS];
    logic [15:0] r_tag [SLOTS];
    logic [SLOTS-1:0] r_armed, r_fired;
    logic [15:0] r_tcnt;
    otq_pkg::t_in_word r_in;

    logic [SW:0]   r_idx;
    logic          r_any, r_due_any, r_free_any;
    logic [47:0]   r_best, r_due_best;
    logic [SW-1:0] r_due_pick, r_free_pick;

    logic [SW-1:0] w_i;
    logic          w_due;
    logic [48:0]   w_sum;
    logic          w_cok;

    otq_pkg::t_out_word n_res;

    assign w_i   = r_idx[SW-1:0];
    assign w_due = r_armed[w_i] && !r_fired[w_i] && r_exp[w_i] <= r_in.time_us;
    assign w_sum = {1'b0, r_in.time_us} + {17'd0, r_ivl[r_due_pick]};
    assign w_cok = ({1'b0, r_in.cancel_slot} < 5'(SLOTS))
        && r_armed[r_in.cancel_slot[SW-1:0]]
        && r_tag[r_in.cancel_slot[SW-1:0]] == r_in.cancel_tag;

    assign o_status.scan_done   = r_idx == (SW+1)'(SLOTS);
    assign o_status.found       = r_due_any;
    assign o_status.next_valid  = r_any;
    assign o_status.next_expiry = r_best;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
        if (i_cmd.scan_clr) begin
            r_idx      <= '0;
            r_any      <= 1'b0;
            r_due_any  <= 1'b0;
            r_free_any <= 1'b0;
        end else if (i_cmd.scan_step && !o_status.scan_done) begin
            r_idx <= r_idx + 1'b1;
            if (r_armed[w_i] && (!r_any || r_exp[w_i] < r_best)) begin
                r_best <= r_exp[w_i];
                r_any  <= 1'b1;
            end
            if (w_due && (!r_due_any || r_exp[w_i] < r_due_best)) begin
                r_due_best <= r_exp[w_i];
                r_due_pick <= w_i;
                r_due_any  <= 1'b1;
            end
            if (!r_armed[w_i] && !r_free_any) begin
                r_free_pick <= w_i;
                r_free_any  <= 1'b1;
            end
        end
        if (i_cmd.do_add && r_free_any) begin
            r_exp[r_free_pick] <= r_in.time_us;
            r_ivl[r_free_pick] <= r_in.repeat_interval;
            r_tag[r_free_pick] <= r_tcnt;
        end
        if (i_cmd.do_fire && r_ivl[r_due_pick] != 32'd0) begin
            r_exp[r_due_pick] <= w_sum[48] ? otq_pkg::TIME_MAX : w_sum[47:0];
        end
        if (!i_rst_n) begin
            r_armed <= '0;
            r_fired <= '0;
            r_tcnt  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_fired <= '0;
            end
            if (i_cmd.do_add && r_free_any) begin
                r_armed[r_free_pick] <= 1'b1;
                r_tcnt <= r_tcnt + 16'd1;
            end
            if (i_cmd.do_cancel && w_cok) begin
                r_armed[r_in.cancel_slot[SW-1:0]] <= 1'b0;
            end
            if (i_cmd.do_fire) begin
                r_fired[r_due_pick] <= 1'b1;
                if (r_ivl[r_due_pick] == 32'd0) begin
                    r_armed[r_due_pick] <= 1'b0;
                end
            end
        end
    end

    // result word; next fields come from the final scan
    always_comb begin
        n_res = o_res;
        if (i_cmd.do_add) begin
            n_res = '0;
            n_res.last = 1'b1;
            if (r_free_any) begin
                n_res.slot             = 4'(r_free_pick);
                n_res.tag              = r_tcnt;
                n_res.accepted         = 1'b1;
                n_res.earliest_changed = !r_any || r_in.time_us < r_best;
            end
        end else if (i_cmd.do_cancel) begin
            n_res = '0;
            n_res.last     = 1'b1;
            n_res.slot     = r_in.cancel_slot;
            n_res.tag      = r_in.cancel_tag;
            n_res.accepted = w_cok;
        end else if (i_cmd.do_fire) begin
            n_res = '0;
            n_res.slot  = 4'(r_due_pick);
            n_res.tag   = r_tag[r_due_pick];
            n_res.fired = 1'b1;
        end else if (i_cmd.load) begin
            n_res = '0;
            n_res.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end
endmodule
`default_nettype wire

// ===== hdl/otq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otq_ctrl
// Sequencer for add, cancel and tick; result buffer and output handshake.
// ----------------------------------------------------------------------------
module otq_ctrl #(
    parameter int SLOTS = otq_pkg::TIMER_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_func,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output otq_pkg::t_out_word      o_out,
    output otq_pkg::t_cmd           o_cmd,
    input  wire otq_pkg::t_status   i_status,
    input  wire otq_pkg::t_out_word i_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_OP, S_FIRE, S_RESCAN, S_RESWAIT, S_FIN, S_EMIT, S_DRAIN
    } t_state;

    localparam int NW = $clog2(SLOTS + 1);

    t_state r_state;
    logic [1:0] r_func;
    logic [NW-1:0] r_nbuf, r_nout;
    logic r_any_fired;
    otq_pkg::t_out_word r_buf [SLOTS];

    function automatic otq_pkg::t_out_word f_emit(input otq_pkg::t_out_word b,
                                                  input otq_pkg::t_status s,
                                                  input logic lst);
        otq_pkg::t_out_word w;
        w = b;
        w.next_valid  = s.next_valid;
        w.next_expiry = s.next_valid ? s.next_expiry : 48'd0;
        w.last        = lst;
        return w;
    endfunction

    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   begin
                o_cmd.load     = i_in_valid;
                o_cmd.scan_clr = i_in_valid;
            end
            S_SCAN, S_RESCAN, S_RESWAIT, S_FIN: o_cmd.scan_step = 1'b1;
            S_OP:     begin
                o_cmd.do_add    = r_func == otq_pkg::FUNC_ADD;
                o_cmd.do_cancel = r_func == otq_pkg::FUNC_CANCEL;
                o_cmd.scan_clr  = 1'b1;
            end
            S_FIRE:   begin
                o_cmd.do_fire  = i_status.found;
                o_cmd.scan_clr = 1'b1;
            end
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_nbuf      <= '0;
            r_nout      <= '0;
            r_any_fired <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_func      <= i_func;
                    r_nbuf      <= '0;
                    r_any_fired <= 1'b0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: if (i_status.scan_done) begin
                    r_state <= (r_func == otq_pkg::FUNC_TICK) ? S_FIRE : S_OP;
                end
                S_OP: r_state <= S_RESWAIT;
                S_FIRE: begin
                    if (i_status.found) begin
                        r_any_fired <= 1'b1;
                        r_state     <= S_RESCAN;
                    end else begin
                        r_state <= S_RESWAIT;
                    end
                end
                S_RESCAN: if (i_status.scan_done) begin
                    r_buf[r_nbuf[$clog2(SLOTS)-1:0]] <= i_res;
                    r_nbuf  <= r_nbuf + 1'b1;
                    r_state <= S_FIRE;
                end
                S_RESWAIT: begin
                    if (!r_any_fired) begin
                        r_buf[0] <= i_res;
                        r_nbuf   <= NW'(1);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: if (i_status.scan_done) begin
                    r_nout  <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    o_out       <= f_emit(r_buf[r_nout[$clog2(SLOTS)-1:0]], i_status,
                                          r_nout + 1'b1 == r_nbuf);
                    o_out_valid <= 1'b1;
                    r_nout      <= r_nout + 1'b1;
                    r_state     <= S_DRAIN;
                end
                S_DRAIN: if (!i_out_stall) begin
                    o_out_valid <= 1'b0;
                    r_state <= (r_nout == r_nbuf) ? S_IDLE : S_EMIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ordered_timer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_timer_queue
// Timer table with add, cancel and tick; due timers fire in order of expiry.
// Each word is scanned once; a tick then fires due timers earliest first with a
// rescan after each, add or cancel is applied, and a final scan gives the next expiry.
// One word at a time, taken only in idle; the scan unit over the slot table sets the rate.
// Reset clears armed and fired bits, the tag counter and the controller state.
// ----------------------------------------------------------------------------
module ordered_timer_queue #(
    parameter int TIMER_SLOTS = otq_pkg::TIMER_SLOTS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire otq_pkg::t_in_word i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output otq_pkg::t_out_word     o_out_data
);
    otq_pkg::t_cmd      w_cmd;
    otq_pkg::t_status   w_status;
    otq_pkg::t_out_word w_res;

    otq_datapath #(.SLOTS(TIMER_SLOTS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in_data),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_res    (w_res)
    );

    otq_ctrl #(.SLOTS(TIMER_SLOTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_in_data.func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out_data),
        .o_cmd       (w_cmd),
        .i_status    (w_status),
        .i_res       (w_res)
    );
endmodule
`default_nettype wire
